>>> sv/rgb565_packbits_rle_encoder_assert.svh
// Assertion macros for the RGB565 PackBits encoder.
// Clocked on clk and disabled while arst_n is low; used by the top level only.
`ifndef RGB565_PACKBITS_RLE_ENCODER_ASSERT_SVH
`define RGB565_PACKBITS_RLE_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RPB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RPB_ASSERT_NOW(lbl, ante, cons, msg)
`define RPB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/rpbrle_pkg.sv
// Shared constants, types and structs of the RGB565 PackBits encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package rpbrle_pkg;

	localparam int MAX_PACKET = 128;
	localparam int MIN_RUN    = 3;
	localparam int TAIL_DEPTH = MIN_RUN - 1;
	localparam int LANES      = 4;
	localparam int LANE_W     = 2;
	localparam int ROWS       = (MAX_PACKET + LANES - 1) / LANES;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W      = ROW_W + LANE_W;
	localparam int CNT_W      = $clog2(MAX_PACKET + 1);
	localparam int TC_W       = $clog2(TAIL_DEPTH + 1);
	localparam int QC_W       = $clog2(MIN_RUN + 1);
	localparam int LEN_W      = 7;
	localparam int OUT_TDATA_W = 80;

	typedef logic [15:0]       pixel_t;
	typedef pixel_t [LANES-1:0] row_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [TC_W-1:0]   tc_t;
	typedef logic [QC_W-1:0]   qc_t;
	typedef logic [ROW_W-1:0]  row_addr_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LANE_W-1:0] lane_t;
	typedef logic [LEN_W-1:0]  len_t;

	localparam cnt_t LIT_MAX    = cnt_t'(MAX_PACKET);
	localparam cnt_t RUN_START  = cnt_t'(MIN_RUN);
	localparam cnt_t ROW_PIX    = cnt_t'(LANES);
	localparam logic [7:0] RUN_FLAG = 8'h80;

	// one output item
	typedef struct packed {
		logic       has_control;
		logic [7:0] control;
		logic [2:0] pixel_count;
		row_t       pix;
		logic       packet_done;
		logic       last;
	} result_t;

	// literal store access
	typedef struct packed {
		logic      wr_en;
		row_addr_t wr_row;
		lane_t     wr_lane;
		pixel_t    wr_data;
		logic      rd_en;
		row_addr_t rd_row;
	} mem_req_t;

	typedef struct packed {
		logic idle;
		cnt_t lit_count;
	} status_t;

endpackage

`default_nettype wire

>>> sv/rgb565_packbits_rle_encoder.sv
// Top level of the RGB565 PackBits run-length encoder: stream ports and output register.
// Depends on rpbrle_pkg, rpbrle_ctrl, rpbrle_lit_store and the assertion header.
`default_nettype none
`include "rgb565_packbits_rle_encoder_assert.svh"

// Encodes a frame of 16-bit RGB565 pixels (s_axis_tlast on the last one) into
// PackBits packets: a run packet (control 0x80 + length-1, one pixel) for 3 to 128
// equal pixels, otherwise literal packets of up to 128 pixels (control length-1)
// delivered four pixels per output item. Pixels are taken one at a time and
// s_axis_tready stays low until the work of the taken pixel is done. A pixel that
// moves a window pixel into the literal buffer is taken first, and a buffer write
// follows. At frame end the window pixels add up to three more buffer writes.
// Each output item waits while the output register is full, and a literal flush
// starts with one row read, then sends one row of up to four per item. The
// sequencer does one buffer write or one row read per cycle; in a flush, each
// further row read waits until the held item is taken.
// The next pixel is taken while the last item still waits on m_axis_tready.
// The literal buffer needs no clearing after reset; only written entries are output.
module rgb565_packbits_rle_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// pixel input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] pixel
	input  logic        s_axis_tlast,   // frame_end
	// packet output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] control, [10:8] pixel_count, [26:11] pixel_a, [42:27] pixel_b,
	// [58:43] pixel_c, [74:59] pixel_d, [79:75] zero
	output logic [rpbrle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [0] has_control, [1] last
	output logic        m_axis_tlast    // packet_done
);

	logic                 res_valid;
	logic                 res_ready;
	rpbrle_pkg::result_t  res;
	rpbrle_pkg::mem_req_t mem_req;
	rpbrle_pkg::row_t     mem_rd_data;
	rpbrle_pkg::status_t  status;

	logic                 out_valid_q;
	rpbrle_pkg::result_t  out_q;

	rpbrle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_pixel    (s_axis_tdata),
		.in_end      (s_axis_tlast),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.status      (status)
	);

	rpbrle_lit_store u_lit_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	// output register: refilled in the cycle the held item is taken
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.pix[3], out_q.pix[2], out_q.pix[1], out_q.pix[0],
		out_q.pixel_count, out_q.control};
	assign m_axis_tuser  = {out_q.last, out_q.has_control};
	assign m_axis_tlast  = out_q.packet_done;

	// item shape
	`RPB_ASSERT_NOW(a_count_range, m_axis_tvalid, (out_q.pixel_count != 3'd0) && (out_q.pixel_count <= 3'd4), "pixel count out of range")
	`RPB_ASSERT_NOW(a_mid_packet_full, m_axis_tvalid && !out_q.packet_done, out_q.pixel_count == 3'd4, "short item inside a literal")
	`RPB_ASSERT_NOW(a_run_shape, m_axis_tvalid && out_q.has_control && out_q.control[7], (out_q.pixel_count == 3'd1) && out_q.packet_done, "malformed run item")
	// buffer fill only moves while the sequencer works
	`RPB_ASSERT_NEXT(a_lit_hold, status.idle && !(s_axis_tvalid && s_axis_tready), $stable(status.lit_count), "literal count moved while idle")

endmodule

`default_nettype wire

>>> sv/rpbrle_lit_store.sv
// Literal pixel buffer: rows of four pixels, one lane written per cycle,
// one row read per cycle with registered data. Uses rpbrle_pkg.
`default_nettype none

module rpbrle_lit_store (
	input  logic                 clk,
	input  rpbrle_pkg::mem_req_t req,
	output rpbrle_pkg::row_t     rd_data
);

	rpbrle_pkg::row_t mem [rpbrle_pkg::ROWS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_row][req.wr_lane] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_row];
		end
	end

endmodule

`default_nettype wire

>>> sv/rpbrle_ctrl.sv
// Packet sequencer: run/tail tracking, literal buffer writes and flush reads.
// Uses rpbrle_pkg; drives the literal store request, reads its row data.
`default_nettype none

module rpbrle_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rpbrle_pkg::pixel_t   in_pixel,
	input  logic                 in_end,
	output logic                 res_valid,
	input  logic                 res_ready,
	output rpbrle_pkg::result_t  res,
	output rpbrle_pkg::mem_req_t mem_req,
	input  rpbrle_pkg::row_t     mem_rd_data,
	output rpbrle_pkg::status_t  status
);

	typedef enum logic [2:0] {
		S_IDLE, S_PRE_RUN, S_PUSH, S_FL_START, S_FL_OUT, S_POST_RUN
	} state_t;

	state_t                  state_q;
	logic                    run_mode_q;
	rpbrle_pkg::pixel_t      run_pixel_q;
	rpbrle_pkg::cnt_t        run_count_q;
	rpbrle_pkg::pixel_t      tail_q [rpbrle_pkg::TAIL_DEPTH];
	rpbrle_pkg::tc_t         tc_q;
	rpbrle_pkg::cnt_t        lit_count_q;
	rpbrle_pkg::pixel_t      queue_q [rpbrle_pkg::MIN_RUN];
	rpbrle_pkg::qc_t         qn_q;
	logic                    post_q;
	logic                    final_q;
	rpbrle_pkg::pixel_t      snap_pix_q;
	rpbrle_pkg::cnt_t        snap_cnt_q;
	rpbrle_pkg::row_addr_t   fl_row_q;
	rpbrle_pkg::cnt_t        fl_rem_q;

	// next values for an accepted item
	logic                    n_run_mode;
	rpbrle_pkg::pixel_t      n_run_pixel;
	rpbrle_pkg::cnt_t        n_run_count;
	rpbrle_pkg::pixel_t      n_tail [rpbrle_pkg::TAIL_DEPTH];
	rpbrle_pkg::tc_t         n_tc;
	rpbrle_pkg::pixel_t      n_queue [rpbrle_pkg::MIN_RUN];
	rpbrle_pkg::qc_t         n_qn;
	logic                    n_pre;
	logic                    n_post;
	logic                    n_final;
	rpbrle_pkg::pixel_t      n_snap_pix;
	rpbrle_pkg::cnt_t        n_snap_cnt;
	state_t                  n_state;

	logic                    take;
	logic                    fire;
	logic                    same;
	logic                    run_match;
	logic                    q_off;
	logic                    last_row;
	logic [2:0]              row_cnt;
	rpbrle_pkg::cnt_t        lit_inc;
	rpbrle_pkg::idx_t        wr_idx;

	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;
	assign res_valid = (state_q == S_PRE_RUN) || (state_q == S_FL_OUT) ||
		(state_q == S_POST_RUN);
	assign fire     = res_valid && res_ready;

	assign status.idle      = (state_q == S_IDLE);
	assign status.lit_count = lit_count_q;

	// flush row geometry
	assign last_row = (fl_rem_q <= rpbrle_pkg::ROW_PIX);
	assign row_cnt  = last_row ? 3'(fl_rem_q) : 3'(rpbrle_pkg::LANES);
	assign lit_inc  = lit_count_q + 1'b1;
	assign wr_idx   = rpbrle_pkg::idx_t'(lit_count_q);

	always_comb begin
		same = 1'b1;
		for (int i = 0; i < rpbrle_pkg::TAIL_DEPTH; i++) begin
			if (tail_q[i] != in_pixel) begin
				same = 1'b0;
			end
		end
	end

	assign run_match = (in_pixel == run_pixel_q) && (run_count_q < rpbrle_pkg::LIT_MAX);

	// step decode: state update plus the list of work for the sequencer
	always_comb begin
		n_run_mode  = run_mode_q;
		n_run_pixel = run_pixel_q;
		n_run_count = run_count_q;
		n_tail      = tail_q;
		n_tc        = tc_q;
		for (int i = 0; i < rpbrle_pkg::MIN_RUN; i++) begin
			n_queue[i] = '0;
		end
		n_qn       = '0;
		n_pre      = 1'b0;
		n_post     = 1'b0;
		n_final    = 1'b0;
		n_snap_pix = run_pixel_q;
		n_snap_cnt = run_count_q;
		q_off      = 1'b0;

		if (run_mode_q) begin
			if (run_match) begin
				n_run_count = run_count_q + 1'b1;
			end else begin
				// run closed by a new pixel; it opens a fresh tail
				n_pre       = 1'b1;
				n_run_mode  = 1'b0;
				n_run_count = '0;
				n_tail[0]   = in_pixel;
				n_tc        = rpbrle_pkg::tc_t'(1);
			end
		end else if (tc_q < rpbrle_pkg::tc_t'(rpbrle_pkg::TAIL_DEPTH)) begin
			for (int i = 0; i < rpbrle_pkg::TAIL_DEPTH; i++) begin
				if (rpbrle_pkg::tc_t'(i) == tc_q) begin
					n_tail[i] = in_pixel;
				end
			end
			n_tc = tc_q + 1'b1;
		end else if (same) begin
			// run found: close any open literal first
			n_final     = (lit_count_q != '0);
			n_run_mode  = 1'b1;
			n_run_pixel = in_pixel;
			n_run_count = rpbrle_pkg::RUN_START;
			n_tc        = '0;
		end else begin
			n_queue[0] = tail_q[0];
			n_qn       = rpbrle_pkg::qc_t'(1);
			for (int i = 0; i < rpbrle_pkg::TAIL_DEPTH - 1; i++) begin
				n_tail[i] = tail_q[i + 1];
			end
			n_tail[rpbrle_pkg::TAIL_DEPTH - 1] = in_pixel;
			n_tc = rpbrle_pkg::tc_t'(rpbrle_pkg::TAIL_DEPTH);
		end

		if (in_end) begin
			if (n_run_mode) begin
				n_pre       = run_mode_q;
				n_post      = !run_mode_q;
				n_snap_pix  = n_run_pixel;
				n_snap_cnt  = n_run_count;
				n_run_mode  = 1'b0;
				n_run_count = '0;
			end
			q_off = (n_qn != '0);
			for (int i = 0; i < rpbrle_pkg::TAIL_DEPTH; i++) begin
				if (rpbrle_pkg::tc_t'(i) < n_tc) begin
					if (q_off) begin
						n_queue[i + 1] = n_tail[i];
					end else begin
						n_queue[i] = n_tail[i];
					end
				end
			end
			n_qn    = n_qn + rpbrle_pkg::qc_t'(n_tc);
			n_tc    = '0;
			n_final = 1'b1;
		end

		if (n_pre) begin
			n_state = S_PRE_RUN;
		end else if (n_qn != '0) begin
			n_state = S_PUSH;
		end else if (n_final && (lit_count_q != '0)) begin
			n_state = S_FL_START;
		end else if (n_post) begin
			n_state = S_POST_RUN;
		end else begin
			n_state = S_IDLE;
		end
	end

	// literal store access
	always_comb begin
		mem_req.wr_en   = (state_q == S_PUSH);
		mem_req.wr_row  = wr_idx[rpbrle_pkg::IDX_W-1:rpbrle_pkg::LANE_W];
		mem_req.wr_lane = wr_idx[rpbrle_pkg::LANE_W-1:0];
		mem_req.wr_data = queue_q[0];
		mem_req.rd_en   = (state_q == S_FL_START) ||
			((state_q == S_FL_OUT) && fire && !last_row);
		mem_req.rd_row  = (state_q == S_FL_START) ? '0 : fl_row_q + 1'b1;
	end

	// result formatting
	always_comb begin
		res = '0;
		case (state_q)
			S_PRE_RUN, S_POST_RUN: begin
				res.has_control = 1'b1;
				res.control     = rpbrle_pkg::RUN_FLAG |
					{1'b0, rpbrle_pkg::len_t'(snap_cnt_q - 1'b1)};
				res.pixel_count = 3'd1;
				res.pix[0]      = snap_pix_q;
				res.packet_done = 1'b1;
				res.last        = (state_q == S_POST_RUN) ||
					((qn_q == '0) && !(final_q && (lit_count_q != '0)));
			end
			S_FL_OUT: begin
				res.has_control = (fl_row_q == '0);
				if (fl_row_q == '0) begin
					res.control = {1'b0, rpbrle_pkg::len_t'(lit_count_q - 1'b1)};
				end
				res.pixel_count = row_cnt;
				for (int i = 0; i < rpbrle_pkg::LANES; i++) begin
					res.pix[i] = (3'(i) < row_cnt) ? mem_rd_data[i] : '0;
				end
				res.packet_done = last_row;
				res.last        = last_row && (qn_q == '0) && !post_q;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_mode_q  <= 1'b0;
			run_pixel_q <= '0;
			run_count_q <= '0;
			for (int i = 0; i < rpbrle_pkg::TAIL_DEPTH; i++) begin
				tail_q[i] <= '0;
			end
			tc_q        <= '0;
			lit_count_q <= '0;
			for (int i = 0; i < rpbrle_pkg::MIN_RUN; i++) begin
				queue_q[i] <= '0;
			end
			qn_q        <= '0;
			post_q      <= 1'b0;
			final_q     <= 1'b0;
			snap_pix_q  <= '0;
			snap_cnt_q  <= '0;
			fl_row_q    <= '0;
			fl_rem_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						run_mode_q  <= n_run_mode;
						run_pixel_q <= n_run_pixel;
						run_count_q <= n_run_count;
						tail_q      <= n_tail;
						tc_q        <= n_tc;
						queue_q     <= n_queue;
						qn_q        <= n_qn;
						post_q      <= n_post;
						final_q     <= n_final;
						snap_pix_q  <= n_snap_pix;
						snap_cnt_q  <= n_snap_cnt;
						state_q     <= n_state;
					end
				end
				S_PRE_RUN: begin
					if (fire) begin
						if (qn_q != '0) begin
							state_q <= S_PUSH;
						end else if (final_q && (lit_count_q != '0)) begin
							state_q <= S_FL_START;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PUSH: begin
					// one pixel into the buffer per cycle
					lit_count_q <= lit_inc;
					for (int i = 0; i < rpbrle_pkg::MIN_RUN - 1; i++) begin
						queue_q[i] <= queue_q[i + 1];
					end
					qn_q <= qn_q - 1'b1;
					if (lit_inc == rpbrle_pkg::LIT_MAX) begin
						state_q <= S_FL_START;
					end else if (qn_q == rpbrle_pkg::qc_t'(1)) begin
						if (final_q) begin
							state_q <= S_FL_START;
						end else if (post_q) begin
							state_q <= S_POST_RUN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FL_START: begin
					fl_row_q <= '0;
					fl_rem_q <= lit_count_q;
					state_q  <= S_FL_OUT;
				end
				S_FL_OUT: begin
					if (fire) begin
						if (last_row) begin
							lit_count_q <= '0;
							if (qn_q != '0) begin
								state_q <= S_PUSH;
							end else if (post_q) begin
								state_q <= S_POST_RUN;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							fl_row_q <= fl_row_q + 1'b1;
							fl_rem_q <= fl_rem_q - rpbrle_pkg::ROW_PIX;
						end
					end
				end
				S_POST_RUN: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
